>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg - shared constants for the echo-pulse ranger
// Reset values, field widths and the fixed-point reciprocal for the cm scale.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int TIMEOUT_BITS   = 20;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 20'd20000;

  localparam int DIST_BITS      = 16;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // 58 us of round trip per cm; pulses of 58 * 2^16 us or more saturate
  localparam int ECHO_US_PER_CM = 58;
  localparam int SAT_US         = ECHO_US_PER_CM * (2 ** DIST_BITS);

  // x / 58 == (x >> 1) / 29 for x below SAT_US; x >> 1 fits in 21 bits
  localparam int HALF_BITS      = 21;
  localparam int RECIP_BITS     = 22;
  localparam int RECIP_SHIFT    = 26;
  localparam logic [RECIP_BITS-1:0] RECIP_29 = 22'd2314099;  // ceil(2^26 / 29)
  localparam int PROD_BITS      = HALF_BITS + RECIP_BITS;

  // packed widths of the stream data words
  localparam int IN_DATA_BITS   = 8;
  localparam int OUT_DATA_BITS  = 24;

endpackage

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger - echo-pulse distance ranger
// Times the echo pulse of an ultrasonic sensor and reports distance in cm.
// ----------------------------------------------------------------------------
// Usage
//   One input item per microsecond tick on s_axis: echo pin level and a poll
//   flag. Each accepted item gives exactly one result item on m_axis: the
//   trigger drive, the held distance, the timeout flag returned to a poll and
//   (in tuser) whether the item answers a poll.
//   timeout_us is written through cfg_wr_en / cfg_wr_data; the user must
//   write it only while idle, as the block does not enforce this. Throughput
//   is one item per clock while m_tready stays high: the control state
//   updates at acceptance, then the pulse width subtract, the reciprocal
//   multiply for /58 and the distance latch each take one register stage.
//   Each stage advances when the one after it is empty or moving, so input is
//   still taken while a result waits, until all four stages are full; a
//   stalled receiver then holds s_tready low.
//   Synchronous reset: time counter and stamps cleared, block idle with the
//   trigger high, timeout flag and distance zero, timeout_us back to 20000.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // config
  input  wire logic                     cfg_wr_en,
  input  wire logic [TIMEOUT_BITS-1:0]  cfg_wr_data,   // timeout_us
  // input items
  input  wire logic                     s_tvalid,
  output      logic                     s_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,       // [0] echo_level, [1] poll
  // result items
  output      logic                     m_tvalid,
  input  wire logic                     m_tready,
  output      logic [OUT_DATA_BITS-1:0] m_tdata,       // [0] trigger_level,
                                                       // [16:1] distance_cm,
                                                       // [17] timeout_error
  output      logic                     m_tuser        // [0] poll_answer
);

  localparam logic [TIME_BITS-1:0] SAT_LIMIT = TIME_BITS'(SAT_US);

  // control state
  logic [TIMEOUT_BITS-1:0] timeout_us;
  logic [TIME_BITS-1:0]    now_time;
  logic [TIME_BITS-1:0]    wait_start;
  logic [TIME_BITS-1:0]    echo_rise_time;
  logic [TIME_BITS-1:0]    echo_fall_time;
  logic                    idle_flag;
  logic                    timeout_flag;
  logic                    last_echo;
  logic                    trigger_reg;

  // pipeline
  logic                    s1_valid, s2_valid, s3_valid;
  logic                    s1_ready, s2_ready, s3_ready, out_ready;
  logic [TIME_BITS-1:0]    s1_rise, s1_fall;
  logic                    s1_req, s1_trig, s1_err, s1_poll;
  logic [HALF_BITS-1:0]    s2_half;
  logic                    s2_latch, s2_sat, s2_trig, s2_err, s2_poll;
  logic [DIST_BITS-1:0]    s3_q;
  logic                    s3_latch, s3_sat, s3_trig, s3_err, s3_poll;
  logic                    out_trig, out_err, out_poll;
  logic [DIST_BITS-1:0]    distance_hold;

  // next-state logic for an accepted item
  logic                    in_accept;
  logic                    echo_in, poll_in;
  logic                    edge_seen;
  logic [TIME_BITS-1:0]    rise_next, fall_next, wait_start_next;
  logic                    idle_mid, trig_mid, tflag_mid;
  logic                    idle_next, trigger_next, timeout_next;
  logic [TIME_BITS-1:0]    waited;
  logic                    expired;

  // stage 2 / 3 combinational
  logic [TIME_BITS:0]      pulse_diff;
  logic                    rise_lt_fall;
  logic [PROD_BITS-1:0]    prod;

  assign out_ready = !m_tvalid || m_tready;
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s_tready  = s1_ready;
  assign in_accept = s_tvalid && s_tready;

  assign echo_in = s_tdata[0];
  assign poll_in = s_tdata[1];

  assign waited  = now_time - wait_start;
  assign expired = waited > {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, timeout_us};

  always_comb begin
    // echo edge first, only while armed
    edge_seen = !idle_flag && (echo_in != last_echo);
    rise_next = echo_rise_time;
    fall_next = echo_fall_time;
    idle_mid  = idle_flag;
    trig_mid  = trigger_reg;
    tflag_mid = timeout_flag;
    if (edge_seen) begin
      if (echo_in) begin
        rise_next = now_time;
        tflag_mid = 1'b0;
      end else begin
        fall_next = now_time;
        idle_mid  = 1'b1;
        trig_mid  = 1'b1;
      end
    end
    // then the poll
    idle_next       = idle_mid;
    trigger_next    = trig_mid;
    timeout_next    = tflag_mid;
    wait_start_next = wait_start;
    if (poll_in) begin
      if (idle_mid) begin
        idle_next       = 1'b0;
        trigger_next    = 1'b0;
        wait_start_next = now_time;
      end else if (expired) begin
        idle_next    = 1'b1;
        trigger_next = 1'b1;
        timeout_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us     <= TIMEOUT_RESET;
      now_time       <= '0;
      wait_start     <= '0;
      echo_rise_time <= '0;
      echo_fall_time <= '0;
      idle_flag      <= 1'b1;
      timeout_flag   <= 1'b0;
      last_echo      <= 1'b0;
      trigger_reg    <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        timeout_us <= cfg_wr_data;
      end
      if (in_accept) begin
        now_time       <= now_time + TIME_BITS'(1);
        wait_start     <= wait_start_next;
        echo_rise_time <= rise_next;
        echo_fall_time <= fall_next;
        idle_flag      <= idle_next;
        timeout_flag   <= timeout_next;
        last_echo      <= echo_in;
        trigger_reg    <= trigger_next;
      end
    end
  end

  // stage 2: pulse width, order check and saturation
  assign pulse_diff   = {1'b0, s1_fall} - {1'b0, s1_rise};
  assign rise_lt_fall = !pulse_diff[TIME_BITS] && (pulse_diff[TIME_BITS-1:0] != '0);

  // stage 3: floor(half / 29) by reciprocal
  assign prod = PROD_BITS'(s2_half) * PROD_BITS'(RECIP_29);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      distance_hold <= '0;
    end else begin
      if (s1_ready) s1_valid <= in_accept;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (out_ready) begin
        m_tvalid <= s3_valid;
        if (s3_valid && s3_latch) begin
          distance_hold <= s3_sat ? DIST_MAX : s3_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_rise <= rise_next;
      s1_fall <= fall_next;
      s1_req  <= poll_in && !timeout_next;
      s1_trig <= trigger_next;
      s1_err  <= poll_in && timeout_next;
      s1_poll <= poll_in;
    end
    if (s1_valid && s2_ready) begin
      s2_half  <= pulse_diff[HALF_BITS:1];
      s2_latch <= s1_req && rise_lt_fall;
      s2_sat   <= pulse_diff[TIME_BITS-1:0] >= SAT_LIMIT;
      s2_trig  <= s1_trig;
      s2_err   <= s1_err;
      s2_poll  <= s1_poll;
    end
    if (s2_valid && s3_ready) begin
      s3_q     <= prod[RECIP_SHIFT +: DIST_BITS];
      s3_latch <= s2_latch;
      s3_sat   <= s2_sat;
      s3_trig  <= s2_trig;
      s3_err   <= s2_err;
      s3_poll  <= s2_poll;
    end
    if (s3_valid && out_ready) begin
      out_trig <= s3_trig;
      out_err  <= s3_err;
      out_poll <= s3_poll;
    end
  end

  assign m_tdata = {{(OUT_DATA_BITS-DIST_BITS-2){1'b0}}, out_err, distance_hold, out_trig};
  assign m_tuser = out_poll;

  // trigger is high exactly when no measurement is armed
  a_trig_idle: assert property (@(posedge clk) disable iff (rst)
    trigger_reg == idle_flag)
    else $error("trigger level out of step with idle flag");

  // input only stalls once every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s2_valid && s3_valid && m_tvalid))
    else $error("input stalled with a free stage");

  // the time counter moves by one per accepted item
  a_tick: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> now_time == TIME_BITS'($past(now_time) + TIME_BITS'(1)))
    else $error("time counter did not advance on an item");

  // a timeout error only ever answers a poll
  a_err_poll: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[DIST_BITS+1]) |-> m_tuser)
    else $error("timeout error on an item that is not a poll");

endmodule

`default_nettype wire
